// ===== hw/rtl/ef3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ef3d_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int GAMMA_WIDTH = 18;
   localparam int RECIP_STEPS = 2 * FRAC_BITS + 1;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic [DATA_WIDTH-2:0]        dens_type;
   typedef logic [GAMMA_WIDTH-1:0]       gamma_type;
   typedef logic [RECIP_STEPS-1:0]       quot_type;
   typedef logic [1:0]                   axis_type;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam word_type WORD_MAX = word_type'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam word_type WORD_MIN = word_type'({1'b1, {(DATA_WIDTH-1){1'b0}}});
   localparam word_type HALF     = word_type'(1) << (FRAC_BITS - 1);
   localparam gamma_type GAMMA_RESET = gamma_type'(26214);

   typedef struct packed {
      logic     bad;
      dens_type rho;
      word_type mx;
      word_type my;
      word_type mz;
      word_type e;
      word_type hs;
   } cell_type;

   typedef struct packed {
      logic                bad;
      word_type [2:0]      mass;
      word_type [2:0][2:0] mom;
      word_type [2:0]      enf;
   } flux_type;

   // magnitude truncated toward zero, then saturated
   function automatic word_type fx_mul(word_type a, word_type b);
      logic signed [2*DATA_WIDTH-1:0]    prod;
      logic [2*DATA_WIDTH-1:0]           mag;
      logic [2*DATA_WIDTH-FRAC_BITS-1:0] r;
      logic                              neg;
      word_type                          res;
      prod = a * b;
      neg  = prod[2*DATA_WIDTH-1];
      mag  = neg ? (~prod + 1'b1) : prod;
      r    = mag[2*DATA_WIDTH-1:FRAC_BITS];
      if (|r[2*DATA_WIDTH-FRAC_BITS-1:DATA_WIDTH-1]) begin
         res = neg ? WORD_MIN : WORD_MAX;
      end else begin
         res = neg ? word_type'(-r[DATA_WIDTH-1:0]) : word_type'(r[DATA_WIDTH-1:0]);
      end
      return res;
   endfunction

   function automatic word_type sat_add(word_type a, word_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[DATA_WIDTH-1:0]);
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[DATA_WIDTH-1:0]);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ef3d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ef3d_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire ef3d_pkg::dens_type rho,
   input  wire ef3d_pkg::word_type mx,
   input  wire ef3d_pkg::word_type my,
   input  wire ef3d_pkg::word_type mz,
   input  wire ef3d_pkg::word_type e,
   output logic                    out_valid,
   output ef3d_pkg::cell_type      out_cell
);

   logic               s1_valid_ff, s1_valid_in;
   ef3d_pkg::cell_type s1_cell_ff, s1_cell_in;
   ef3d_pkg::word_type sqx_ff, sqy_ff, sqz_ff, sqx_in, sqy_in, sqz_in;
   logic               s2_valid_ff, s2_valid_in;
   ef3d_pkg::cell_type s2_cell_ff, s2_cell_in;
   ef3d_pkg::word_type sq;

   always_comb begin
      s1_valid_in    = in_valid;
      s1_cell_in.bad = (rho == '0);
      s1_cell_in.rho = rho;
      s1_cell_in.mx  = mx;
      s1_cell_in.my  = my;
      s1_cell_in.mz  = mz;
      s1_cell_in.e   = e;
      s1_cell_in.hs  = '0;
      sqx_in = ef3d_pkg::fx_mul(mx, mx);
      sqy_in = ef3d_pkg::fx_mul(my, my);
      sqz_in = ef3d_pkg::fx_mul(mz, mz);

      sq = ef3d_pkg::sat_add(ef3d_pkg::sat_add(sqx_ff, sqy_ff), sqz_ff);
      s2_valid_in   = s1_valid_ff;
      s2_cell_in    = s1_cell_ff;
      s2_cell_in.hs = ef3d_pkg::fx_mul(ef3d_pkg::HALF, sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (en) begin
         s1_cell_ff <= s1_cell_in;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         sqz_ff     <= sqz_in;
         s2_cell_ff <= s2_cell_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_cell  = s2_cell_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ef3d_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ef3d_recip (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire ef3d_pkg::cell_type in_cell,
   output logic                    out_valid,
   output ef3d_pkg::word_type      out_irho,
   output ef3d_pkg::cell_type      out_cell
);

   localparam int NS = ef3d_pkg::RECIP_STEPS;
   localparam int DW = ef3d_pkg::DATA_WIDTH;

   logic                valid_ff [NS];
   logic [DW-1:0]       rem_ff   [NS];
   ef3d_pkg::quot_type  q_ff     [NS];
   ef3d_pkg::cell_type  cell_ff  [NS];

   // restoring division of 2^(2*FRAC_BITS) by rho, one quotient bit per stage
   for (genvar j = 0; j < NS; j++) begin : g_step
      logic               v_prev;
      logic [DW-1:0]      rem_prev;
      ef3d_pkg::quot_type q_prev;
      ef3d_pkg::cell_type c_prev;
      logic [DW-1:0]      shifted;
      logic [DW-1:0]      divisor;
      logic               fits;
      logic               valid_in;
      logic [DW-1:0]      rem_in;
      ef3d_pkg::quot_type q_in;

      if (j == 0) begin : g_first
         assign v_prev   = in_valid;
         assign rem_prev = '0;
         assign q_prev   = '0;
         assign c_prev   = in_cell;
      end else begin : g_next
         assign v_prev   = valid_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign c_prev   = cell_ff[j-1];
      end

      always_comb begin
         shifted  = {rem_prev[DW-2:0], 1'(j == 0)};
         divisor  = {1'b0, c_prev.rho};
         fits     = (shifted >= divisor);
         valid_in = v_prev;
         rem_in   = fits ? (shifted - divisor) : shifted;
         q_in     = q_prev;
         q_in[NS-1-j] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_in;
         end
         if (en) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            cell_ff[j] <= c_prev;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_cell  = cell_ff[NS-1];
   assign out_irho  = (|q_ff[NS-1][NS-1:DW-1]) ? ef3d_pkg::WORD_MAX
                                              : ef3d_pkg::word_type'(q_ff[NS-1][DW-1:0]);

endmodule
`default_nettype wire

// ===== hw/rtl/ef3d_flux.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ef3d_flux (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire ef3d_pkg::gamma_type gamma,
   input  wire logic                in_valid,
   input  wire ef3d_pkg::word_type  irho,
   input  wire ef3d_pkg::cell_type  in_cell,
   output logic                     out_valid,
   output ef3d_pkg::flux_type       out_flux
);

   typedef ef3d_pkg::word_type word_type;

   logic     valid_ff [5];
   logic     valid_in [5];
   logic     bad_ff   [5];
   word_type m_ff     [5][3];
   word_type e_ff     [3];
   word_type v_ff     [4][3];
   word_type ke1_ff, ke1_in;
   word_type d2_ff, d2_in;
   word_type p3_ff, p3_in;
   word_type ep4_ff, ep4_in;
   word_type f3_ff [3][3];
   word_type f3_in [3][3];
   word_type f4_ff [3][3];
   word_type f4_in [3][3];
   word_type f5_ff [3][3];
   word_type v1_in [3];
   word_type ef5_ff [3];
   word_type ef5_in [3];
   word_type m_in  [3];
   word_type g;

   always_comb begin
      g = word_type'(gamma);
      m_in[0] = in_cell.mx;
      m_in[1] = in_cell.my;
      m_in[2] = in_cell.mz;
      valid_in[0] = in_valid;
      for (int s = 1; s < 5; s++) begin
         valid_in[s] = valid_ff[s-1];
      end

      ke1_in = ef3d_pkg::fx_mul(in_cell.hs, irho);
      for (int a = 0; a < 3; a++) begin
         v1_in[a] = ef3d_pkg::fx_mul(irho, m_in[a]);
      end

      d2_in = ef3d_pkg::sat_sub(e_ff[0], ke1_ff);

      p3_in = ef3d_pkg::fx_mul(g, d2_ff);
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            f3_in[a][k] = ef3d_pkg::fx_mul(v_ff[1][a], m_ff[1][k]);
         end
      end

      ep4_in = ef3d_pkg::sat_add(e_ff[2], p3_ff);
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            f4_in[a][k] = (a == k) ? ef3d_pkg::sat_add(f3_ff[a][k], p3_ff) : f3_ff[a][k];
         end
      end

      for (int a = 0; a < 3; a++) begin
         ef5_in[a] = ef3d_pkg::fx_mul(v_ff[3][a], ep4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 5; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         for (int s = 0; s < 5; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
      if (en) begin
         bad_ff[0] <= in_cell.bad;
         e_ff[0]   <= in_cell.e;
         ke1_ff    <= ke1_in;
         for (int a = 0; a < 3; a++) begin
            m_ff[0][a] <= m_in[a];
            v_ff[0][a] <= v1_in[a];
         end
         for (int s = 1; s < 5; s++) begin
            bad_ff[s] <= bad_ff[s-1];
            for (int a = 0; a < 3; a++) begin
               m_ff[s][a] <= m_ff[s-1][a];
            end
         end
         for (int s = 1; s < 3; s++) begin
            e_ff[s] <= e_ff[s-1];
         end
         for (int s = 1; s < 4; s++) begin
            for (int a = 0; a < 3; a++) begin
               v_ff[s][a] <= v_ff[s-1][a];
            end
         end
         d2_ff  <= d2_in;
         p3_ff  <= p3_in;
         ep4_ff <= ep4_in;
         for (int a = 0; a < 3; a++) begin
            ef5_ff[a] <= ef5_in[a];
            for (int k = 0; k < 3; k++) begin
               f3_ff[a][k] <= f3_in[a][k];
               f4_ff[a][k] <= f4_in[a][k];
               // hold the momentum terms one more stage to line up with the energy product
               f5_ff[a][k] <= f4_ff[a][k];
            end
         end
      end
   end

   always_comb begin
      out_flux.bad = bad_ff[4];
      for (int a = 0; a < 3; a++) begin
         out_flux.mass[a] = m_ff[4][a];
         out_flux.enf[a]  = ef5_ff[a];
         for (int k = 0; k < 3; k++) begin
            out_flux.mom[a][k] = f5_ff[a][k];
         end
      end
   end

   assign out_valid = valid_ff[4];

endmodule
`default_nettype wire

// ===== hw/rtl/ef3d_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ef3d_serial (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire ef3d_pkg::flux_type in_flux,
   output logic                    take,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ef3d_pkg::axis_type      out_axis,
   output ef3d_pkg::word_type      out_mass,
   output ef3d_pkg::word_type      out_xmom,
   output ef3d_pkg::word_type      out_ymom,
   output ef3d_pkg::word_type      out_zmom,
   output ef3d_pkg::word_type      out_energy,
   output logic                    out_bad,
   output logic                    out_last
);

   logic               full_ff, full_in;
   ef3d_pkg::axis_type axis_ff, axis_in;
   ef3d_pkg::flux_type res_ff;
   logic [1:0]         sel;

   // load a new cell when empty or when its last beat leaves
   assign take = !full_ff || (out_ready && axis_ff == ef3d_pkg::AXIS_Z);

   always_comb begin
      full_in = full_ff;
      axis_in = axis_ff;
      if (take) begin
         full_in = in_valid;
         axis_in = ef3d_pkg::AXIS_X;
      end else if (out_ready) begin
         axis_in = axis_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         axis_ff <= ef3d_pkg::AXIS_X;
      end else begin
         full_ff <= full_in;
         axis_ff <= axis_in;
      end
      if (take) begin
         res_ff <= in_flux;
      end
   end

   always_comb begin
      unique case (axis_ff)
         ef3d_pkg::AXIS_X: sel = 2'd0;
         ef3d_pkg::AXIS_Y: sel = 2'd1;
         ef3d_pkg::AXIS_Z: sel = 2'd2;
         default:          sel = 2'd0;
      endcase
      out_mass   = res_ff.mass[sel];
      out_xmom   = res_ff.mom[sel][0];
      out_ymom   = res_ff.mom[sel][1];
      out_zmom   = res_ff.mom[sel][2];
      out_energy = res_ff.enf[sel];
      if (res_ff.bad) begin
         out_mass   = '0;
         out_xmom   = '0;
         out_ymom   = '0;
         out_zmom   = '0;
         out_energy = '0;
      end
   end

   assign out_valid = full_ff;
   assign out_axis  = axis_ff;
   assign out_bad   = res_ff.bad;
   assign out_last  = (axis_ff == ef3d_pkg::AXIS_Z);

endmodule
`default_nettype wire

// ===== hw/rtl/euler_flux_3d.sv =====
// Path: front stages, reciprocal divider, flux stages, then the output register; the x
// beat of a cell comes first, and y and z follow on the next accepted output cycles.
// Rate: each cell takes three beats on the result port; the 33-stage reciprocal divider
// and the multiplier stages take a new cell every cycle while the pipe is not stalled.
// Reset: synchronous, active high; empties the pipeline and sets gamma minus one to 0.4.
`timescale 1ns / 1ps
`default_nettype none
module euler_flux_3d (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ef3d_pkg::dens_type  req_density,
   input  wire ef3d_pkg::word_type  req_momentum_x,
   input  wire ef3d_pkg::word_type  req_momentum_y,
   input  wire ef3d_pkg::word_type  req_momentum_z,
   input  wire ef3d_pkg::word_type  req_energy,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output ef3d_pkg::axis_type       rsp_axis,
   output ef3d_pkg::word_type       rsp_mass_flux,
   output ef3d_pkg::word_type       rsp_xmom_flux,
   output ef3d_pkg::word_type       rsp_ymom_flux,
   output ef3d_pkg::word_type       rsp_zmom_flux,
   output ef3d_pkg::word_type       rsp_energy_flux,
   output logic                     rsp_bad_density,
   output logic                     rsp_last,
   input  wire logic                csr_we,
   input  wire ef3d_pkg::gamma_type csr_wdata
);

   ef3d_pkg::gamma_type gamma_ff, gamma_in;
   logic                en;
   logic                take;
   logic                front_valid, recip_valid, flux_valid;
   ef3d_pkg::cell_type  front_cell, recip_cell;
   ef3d_pkg::word_type  irho;
   ef3d_pkg::flux_type  flux;

   assign gamma_in = csr_we ? csr_wdata : gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= ef3d_pkg::GAMMA_RESET;
      end else begin
         gamma_ff <= gamma_in;
      end
   end

   // advance the whole pipe unless a finished cell waits on a busy output
   assign en        = !flux_valid || take;
   assign req_ready = en;

   ef3d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .rho       (req_density),
      .mx        (req_momentum_x),
      .my        (req_momentum_y),
      .mz        (req_momentum_z),
      .e         (req_energy),
      .out_valid (front_valid),
      .out_cell  (front_cell)
   );

   ef3d_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_cell   (front_cell),
      .out_valid (recip_valid),
      .out_irho  (irho),
      .out_cell  (recip_cell)
   );

   ef3d_flux u_flux (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .gamma     (gamma_ff),
      .in_valid  (recip_valid),
      .irho      (irho),
      .in_cell   (recip_cell),
      .out_valid (flux_valid),
      .out_flux  (flux)
   );

   ef3d_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (flux_valid),
      .in_flux    (flux),
      .take       (take),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_axis   (rsp_axis),
      .out_mass   (rsp_mass_flux),
      .out_xmom   (rsp_xmom_flux),
      .out_ymom   (rsp_ymom_flux),
      .out_zmom   (rsp_zmom_flux),
      .out_energy (rsp_energy_flux),
      .out_bad    (rsp_bad_density),
      .out_last   (rsp_last)
   );

endmodule
`default_nettype wire
